// File: rtl/ple_pkg.sv
// package for the positional list engine: op codes, widths, defaults
// no dependencies
`default_nettype none
package ple_pkg;
    localparam int CAPACITY_DEF   = 64;
    localparam int DATA_WIDTH_DEF = 8;
    localparam int OP_W  = 4;
    localparam int POS_W = 7;
    localparam int VAL_W = 8;

    typedef enum logic [OP_W-1:0] {
        OP_INS_HEAD = 4'd0,
        OP_INS_TAIL = 4'd1,
        OP_INS_POS  = 4'd2,
        OP_DEL_HEAD = 4'd3,
        OP_DEL_TAIL = 4'd4,
        OP_DEL_POS  = 4'd5,
        OP_SEARCH   = 4'd6,
        OP_UPD_POS  = 4'd7,
        OP_UPD_VAL  = 4'd8,
        OP_REVERSE  = 4'd9,
        OP_EMPTY    = 4'd10
    } t_op;

    typedef enum logic [2:0] {
        CA_HOLD   = 3'd0,
        CA_OPEN   = 3'd1,
        CA_CLOSE  = 3'd2,
        CA_WRITE  = 3'd3,
        CA_MIRROR = 3'd4
    } t_cell_act;

    typedef struct packed {
        t_cell_act act;
        logic      at_tgt;
        logic      after_tgt;
    } t_cell_ctl;
endpackage
`default_nettype wire

// File: rtl/ple_cell.sv
// one list cell: holds an entry, shifts with its neighbors, compares
// depends on ple_pkg
`default_nettype none
module ple_cell #(
    parameter int DATA_WIDTH = 8
) (
    input  wire logic                  i_clk,
    input  wire ple_pkg::t_cell_ctl    i_ctl,
    input  wire logic [DATA_WIDTH-1:0] i_left,
    input  wire logic [DATA_WIDTH-1:0] i_right,
    input  wire logic [DATA_WIDTH-1:0] i_mirror,
    input  wire logic [DATA_WIDTH-1:0] i_wdata,
    input  wire logic [DATA_WIDTH-1:0] i_cmp,
    output logic      [DATA_WIDTH-1:0] o_data,
    output logic                       o_match
);
    import ple_pkg::*;
    logic [DATA_WIDTH-1:0] r_data, n_data;

    always_comb begin
        n_data = r_data;
        unique case (i_ctl.act)
            CA_OPEN:   if (i_ctl.at_tgt) n_data = i_wdata;
                       else if (i_ctl.after_tgt) n_data = i_left;
            CA_CLOSE:  if (i_ctl.at_tgt || i_ctl.after_tgt) n_data = i_right;
            CA_WRITE:  if (i_ctl.at_tgt) n_data = i_wdata;
            CA_MIRROR: if (i_ctl.after_tgt) n_data = i_mirror;
            default:   n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data  = r_data;
    assign o_match = (r_data == i_cmp);
endmodule
`default_nettype wire

// File: rtl/positional_list_engine.sv
// top level of the positional list engine: command decode, length and cells
// depends on ple_pkg and ple_cell
// Usage: commands arrive on the input channel (i_valid/o_stall) with
// i_op, i_position, i_value and i_new_value. Each accepted transfer gives
// exactly one result on the output channel (o_valid/i_stall) carrying
// o_status, o_found_position, o_count and o_is_empty.
// The row of cells shifts, compares or mirrors in the cycle the command is
// accepted and the result is registered at that edge. Throughput is one
// command per cycle while the receiver takes results; each cell updates
// from its neighbors or, on reverse, from its mirror in a single step.
// Search and update by value use a parallel compare in every cell with a
// first-match pick across the row.
// When the receiver stalls, the result stays in the output register and
// o_stall rises so no command is taken until the result leaves.
// Reset clears the length and the output valid; entry contents are
// left undefined and are never read before written.
`default_nettype none
module positional_list_engine #(
    parameter int CAPACITY   = ple_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = ple_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_stall,
    input  wire logic [ple_pkg::OP_W-1:0]  i_op,
    input  wire logic [ple_pkg::POS_W-1:0] i_position,
    input  wire logic [ple_pkg::VAL_W-1:0] i_value,
    input  wire logic [ple_pkg::VAL_W-1:0] i_new_value,
    output logic                           o_valid,
    input  wire logic                      i_stall,
    output logic                           o_status,
    output logic      [ple_pkg::POS_W-1:0] o_found_position,
    output logic      [ple_pkg::POS_W-1:0] o_count,
    output logic                           o_is_empty
);
    import ple_pkg::*;

    localparam int LW = $clog2(CAPACITY + 1);
    localparam int PW = (LW > POS_W) ? LW : POS_W;
    localparam int DW = (DATA_WIDTH < VAL_W) ? DATA_WIDTH : VAL_W;

    logic [LW-1:0] r_len, n_len;
    logic          r_ovalid, r_status;
    logic [POS_W-1:0] r_found;
    logic accept;

    logic [DATA_WIDTH-1:0] data [CAPACITY];
    logic [CAPACITY-1:0]   match;
    t_cell_ctl             ctl [CAPACITY];
    logic [DATA_WIDTH-1:0] val, nval, wdata, cmp;

    logic [PW-1:0] len_x, pos_x, tgt;
    t_cell_act act;
    logic ok;
    logic [PW-1:0] first;
    logic          any;

    assign o_stall = r_ovalid && i_stall;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        val  = '0;
        nval = '0;
        val[DW-1:0]  = i_value[DW-1:0];
        nval[DW-1:0] = i_new_value[DW-1:0];
    end

    assign len_x = PW'(r_len);
    assign pos_x = PW'(i_position);
    assign cmp   = val;

    always_comb begin
        first = '0;
        any   = 1'b0;
        for (int k = CAPACITY - 1; k >= 0; k--) begin
            if (match[k] && (PW'(k) < len_x)) begin
                first = PW'(k + 1);
                any   = 1'b1;
            end
        end
    end

    always_comb begin
        act   = CA_HOLD;
        ok    = 1'b0;
        tgt   = '0;
        wdata = val;
        n_len = r_len;
        unique case (i_op)
            OP_INS_HEAD, OP_INS_TAIL, OP_INS_POS: begin
                if (i_op == OP_INS_HEAD)      tgt = PW'(1);
                else if (i_op == OP_INS_TAIL) tgt = len_x + PW'(1);
                else                          tgt = pos_x;
                if (len_x < PW'(CAPACITY) && tgt >= PW'(1) && tgt <= len_x + PW'(1)) begin
                    ok = 1'b1; act = CA_OPEN; n_len = r_len + LW'(1);
                end
            end
            OP_DEL_HEAD, OP_DEL_TAIL, OP_DEL_POS: begin
                if (i_op == OP_DEL_HEAD)      tgt = PW'(1);
                else if (i_op == OP_DEL_TAIL) tgt = len_x;
                else                          tgt = pos_x;
                if (tgt >= PW'(1) && tgt <= len_x) begin
                    ok = 1'b1; act = CA_CLOSE; n_len = r_len - LW'(1);
                end
            end
            OP_SEARCH: ok = (len_x != '0);
            OP_UPD_POS: begin
                tgt = pos_x;
                if (tgt >= PW'(1) && tgt <= len_x) begin
                    ok = 1'b1; act = CA_WRITE;
                end
            end
            OP_UPD_VAL: begin
                tgt = first; wdata = nval;
                if (any) begin
                    ok = 1'b1; act = CA_WRITE;
                end
            end
            OP_REVERSE: begin
                tgt = PW'(1);
                if (len_x != '0) begin
                    ok = 1'b1; act = CA_MIRROR;
                end
            end
            OP_EMPTY: ok = 1'b1;
            default:  ok = 1'b0;
        endcase
        if (!accept) begin
            act = CA_HOLD; n_len = r_len;
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] left_d, right_d, mir_d;
        logic [PW-1:0] p;
        assign p       = PW'(g + 1);
        assign left_d  = (g == 0) ? wdata : data[(g == 0) ? 0 : g - 1];
        assign right_d = (g == CAPACITY - 1) ? data[g] : data[(g == CAPACITY - 1) ? g : g + 1];
        always_comb begin
            mir_d = data[g];
            for (int m = 0; m < CAPACITY; m++) begin
                if (m + g + 1 == int'(len_x)) mir_d = data[m];
            end
        end
        always_comb begin
            ctl[g].act       = act;
            ctl[g].at_tgt    = (p == tgt);
            ctl[g].after_tgt = (act == CA_MIRROR) ? (p <= len_x)
                             : (act == CA_OPEN) ? (p > tgt && p <= len_x + PW'(1))
                             : (p > tgt && p < len_x);
        end
        ple_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (ctl[g]),
            .i_left  (left_d),
            .i_right (right_d),
            .i_mirror(mir_d),
            .i_wdata (wdata),
            .i_cmp   (cmp),
            .o_data  (data[g]),
            .o_match (match[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_len <= n_len;
            if (accept) r_ovalid <= 1'b1;
            else if (!i_stall) r_ovalid <= 1'b0;
        end
        if (accept) begin
            r_status <= !ok;
            r_found  <= (i_op == OP_SEARCH && ok) ? POS_W'(first) : '0;
        end
    end

    assign o_valid          = r_ovalid;
    assign o_status         = r_status;
    assign o_found_position = r_found;
    assign o_count          = POS_W'(r_len);
    assign o_is_empty       = (r_len == '0);
endmodule
`default_nettype wire
